// File: rtl/core/mfa_pkg.sv
// Package with shared types and constants of the mixed fraction accumulator.
`default_nettype none
package mfa_pkg;

  localparam int W     = 63;
  localparam int CNT_W = $clog2(W);

  typedef logic [W-1:0] val_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_MUL  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_ZDEN = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic {
    MODE_DIV = 1'b0,
    MODE_MUL = 1'b1
  } mode_t;

  // Request from the sequencer to the shared divide/multiply unit.
  typedef struct packed {
    logic  start;
    mode_t mode;
  } req_t;

endpackage
`default_nettype wire

// File: rtl/core/mfa_ifs.sv
// Valid/ready channel interfaces for operations and results.
`default_nettype none
interface mfa_in_if;
  import mfa_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] op;
  val_t in_whole;
  val_t in_num;
  val_t in_den;
  val_t factor;
  modport source (output valid, op, in_whole, in_num, in_den, factor, input ready);
  modport sink (input valid, op, in_whole, in_num, in_den, factor, output ready);
endinterface

interface mfa_out_if;
  import mfa_pkg::*;
  logic valid;
  logic ready;
  val_t res_whole;
  val_t res_num;
  val_t res_den;
  logic [1:0] status;
  modport source (output valid, res_whole, res_num, res_den, status, input ready);
  modport sink (input valid, res_whole, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mfa_unit.sv
// Shared bit-serial divider and overflow-checking multiplier, one bit per cycle.
`default_nettype none
module mfa_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mfa_pkg::req_t req,
  input  wire mfa_pkg::val_t a,
  input  wire mfa_pkg::val_t b,
  output logic               done,
  output mfa_pkg::val_t      quo,
  output mfa_pkg::val_t      rem,
  output mfa_pkg::val_t      prod,
  output logic               ovf
);
  import mfa_pkg::*;

  logic [W+1:0]   acc_r, acc_nxt;
  val_t           sh_r, sh_nxt;
  val_t           b_r, b_nxt;
  mode_t          mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           ovf_r, ovf_nxt;
  logic [W:0]     r2;
  logic           ge;
  logic [W+1:0]   p2;

  always_comb begin
    r2 = {acc_r[W-1:0], sh_r[W-1]};
    ge = (r2 >= {1'b0, b_r});
    p2 = {acc_r[W:0], 1'b0} + (sh_r[W-1] ? {2'b00, b_r} : '0);
  end

  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    if (req.start) begin
      acc_nxt  = '0;
      mode_nxt = req.mode;
      b_nxt    = (req.mode == MODE_DIV) ? b : a;
      sh_nxt   = (req.mode == MODE_DIV) ? a : b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      if (mode_r == MODE_DIV) begin
        acc_nxt = {2'b00, ge ? (r2[W-1:0] - b_r) : r2[W-1:0]};
        sh_nxt  = {sh_r[W-2:0], ge};
      end else begin
        acc_nxt = p2;
        sh_nxt  = {sh_r[W-2:0], 1'b0};
        ovf_nxt = ovf_r | (|p2[W+1:W]);
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r  <= acc_nxt;
    sh_r   <= sh_nxt;
    b_r    <= b_nxt;
    mode_r <= mode_nxt;
    cnt_r  <= cnt_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign done = done_r;
  assign quo  = sh_r;
  assign rem  = acc_r[W-1:0];
  assign prod = acc_r[W-1:0];
  assign ovf  = ovf_r;

endmodule
`default_nettype wire

// File: rtl/core/mixed_fraction_accumulator_top.sv
// Top level: sequencer for load, add and multiply of a reduced mixed fraction.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | op, in_whole, in_num, in_den, factor
//  out_ch  | out | valid/ready      | res_whole, res_num, res_den, status
//
// One transaction at a time. Every divide or multiply runs on one shared
// bit-serial unit. A load divides the numerator by the denominator, then runs
// the Euclid steps of a gcd and divides both parts by it; a multiply runs two
// multiplies before the same reduction; an add reduces its operand, runs a gcd,
// two divides and three multiplies, then reduces the result. An overflow ends the sequence early.
// Zero-denominator and unused operations go straight to the result.
// Reset is synchronous and returns the value to 0 + 0/1.
// in_ch.ready is low from acceptance until the result transaction completes;
// a stalled result holds the block.
`default_nettype none
module mixed_fraction_accumulator_top (
  input wire logic clk,
  input wire logic rst_n,
  mfa_in_if.sink   in_ch,
  mfa_out_if.source out_ch
);
  import mfa_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_NDIV = 14'b00000000000010,
    S_GCD  = 14'b00000000000100,
    S_RN   = 14'b00000000001000,
    S_RD   = 14'b00000000010000,
    S_A1   = 14'b00000000100000,
    S_A2   = 14'b00000001000000,
    S_A3   = 14'b00000010000000,
    S_A4   = 14'b00000100000000,
    S_A5   = 14'b00001000000000,
    S_M1   = 14'b00010000000000,
    S_M2   = 14'b00100000000000,
    S_OUT  = 14'b01000000000000,
    S_SPR  = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_OPD = 2'd0,
    PH_ADD = 2'd1,
    PH_RES = 2'd2,
    PH_UNU = 2'd3
  } phase_t;

  state_t  state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  op_t     op_r, op_nxt;
  status_t status_r, status_nxt;
  logic    start_r, start_nxt;
  val_t ow_r, ow_nxt, on_r, on_nxt, od_r, od_nxt, f_r, f_nxt;
  val_t aw_r, aw_nxt, an_r, an_nxt, ad_r, ad_nxt;
  val_t rw_r, rw_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  val_t x_r, x_nxt, y_r, y_nxt, g_r, g_nxt, ta_r, ta_nxt, t1_r, t1_nxt;

  req_t  req;
  val_t  ua, ub, quo, rem, prod;
  logic  udone, uovf;
  logic [W:0] sum;

  // Operands of the shared unit follow the current step.
  always_comb begin
    req.start = start_r;
    req.mode  = MODE_DIV;
    ua = rn_r;
    ub = rd_r;
    unique case (state_r)
      S_GCD:  begin ua = x_r;  ub = y_r; end
      S_RN:   begin ua = rn_r; ub = g_r; end
      S_RD:   begin ua = rd_r; ub = g_r; end
      S_A1:   begin ua = od_r; ub = g_r; end
      S_A2:   begin req.mode = MODE_MUL; ua = ta_r; ub = an_r; end
      S_A3:   begin ua = ad_r; ub = g_r; end
      S_A4:   begin req.mode = MODE_MUL; ua = ta_r; ub = on_r; end
      S_A5:   begin req.mode = MODE_MUL; ua = ta_r; ub = od_r; end
      S_M1:   begin req.mode = MODE_MUL; ua = aw_r; ub = f_r; end
      S_M2:   begin req.mode = MODE_MUL; ua = an_r; ub = f_r; end
      default: begin ua = rn_r; ub = rd_r; end
    endcase
  end

  mfa_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .a    (ua),
    .b    (ub),
    .done (udone),
    .quo  (quo),
    .rem  (rem),
    .prod (prod),
    .ovf  (uovf)
  );

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    start_nxt  = 1'b0;
    ow_nxt = ow_r; on_nxt = on_r; od_nxt = od_r; f_nxt = f_r;
    aw_nxt = aw_r; an_nxt = an_r; ad_nxt = ad_r;
    rw_nxt = rw_r; rn_nxt = rn_r; rd_nxt = rd_r;
    x_nxt = x_r; y_nxt = y_r; g_nxt = g_r; ta_nxt = ta_r; t1_nxt = t1_r;
    sum = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = op_t'(in_ch.op);
          f_nxt      = in_ch.factor;
          status_nxt = ST_OK;
          unique case (op_t'(in_ch.op))
            OP_LOAD, OP_ADD: begin
              if (in_ch.in_den == '0) begin
                status_nxt = ST_ZDEN;
                state_nxt  = S_OUT;
              end else begin
                rw_nxt    = in_ch.in_whole;
                rn_nxt    = in_ch.in_num;
                rd_nxt    = in_ch.in_den;
                phase_nxt = PH_OPD;
                state_nxt = S_NDIV;
                start_nxt = 1'b1;
              end
            end
            OP_MUL: begin
              state_nxt = S_M1;
              start_nxt = 1'b1;
            end
            OP_NOP: state_nxt = S_OUT;
          endcase
        end
      end
      S_NDIV: if (udone) begin
        sum = {1'b0, rw_r} + {1'b0, quo};
        if (sum[W]) begin
          status_nxt = ST_OVF;
          state_nxt  = S_OUT;
        end else begin
          rw_nxt    = sum[W-1:0];
          rn_nxt    = rem;
          x_nxt     = rem;
          y_nxt     = rd_r;
          state_nxt = S_GCD;
          start_nxt = 1'b1;
        end
      end
      S_GCD: if (udone) begin
        x_nxt = y_r;
        y_nxt = rem;
        start_nxt = 1'b1;
        if (rem == '0) begin
          g_nxt = y_r;
          if (phase_r == PH_ADD) begin
            sum = {1'b0, aw_r} + {1'b0, ow_r};
            rw_nxt = sum[W-1:0];
            if (sum[W]) begin
              status_nxt = ST_OVF;
              state_nxt  = S_OUT;
              start_nxt  = 1'b0;
            end else begin
              state_nxt = S_A1;
            end
          end else begin
            state_nxt = S_RN;
          end
        end
      end
      S_RN: if (udone) begin
        rn_nxt    = quo;
        state_nxt = S_RD;
        start_nxt = 1'b1;
      end
      S_RD: if (udone) begin
        rd_nxt = quo;
        if (phase_r == PH_OPD && op_r == OP_ADD) begin
          ow_nxt    = rw_r;
          on_nxt    = rn_r;
          od_nxt    = quo;
          x_nxt     = ad_r;
          y_nxt     = quo;
          phase_nxt = PH_ADD;
          state_nxt = S_GCD;
          start_nxt = 1'b1;
        end else begin
          aw_nxt    = rw_r;
          an_nxt    = rn_r;
          ad_nxt    = quo;
          state_nxt = S_OUT;
        end
      end
      S_A1: if (udone) begin
        ta_nxt    = quo;
        state_nxt = S_A2;
        start_nxt = 1'b1;
      end
      S_A2: if (udone) begin
        t1_nxt = prod;
        if (uovf) begin
          status_nxt = ST_OVF;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_A3;
          start_nxt = 1'b1;
        end
      end
      S_A3: if (udone) begin
        ta_nxt    = quo;
        state_nxt = S_A4;
        start_nxt = 1'b1;
      end
      S_A4: if (udone) begin
        sum = {1'b0, t1_r} + {1'b0, prod};
        rn_nxt = sum[W-1:0];
        if (uovf || sum[W]) begin
          status_nxt = ST_OVF;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_A5;
          start_nxt = 1'b1;
        end
      end
      S_A5: if (udone) begin
        rd_nxt = prod;
        if (uovf) begin
          status_nxt = ST_OVF;
          state_nxt  = S_OUT;
        end else begin
          phase_nxt = PH_RES;
          state_nxt = S_NDIV;
          start_nxt = 1'b1;
        end
      end
      S_M1: if (udone) begin
        rw_nxt = prod;
        if (uovf) begin
          status_nxt = ST_OVF;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_M2;
          start_nxt = 1'b1;
        end
      end
      S_M2: if (udone) begin
        rn_nxt = prod;
        rd_nxt = ad_r;
        if (uovf) begin
          status_nxt = ST_OVF;
          state_nxt  = S_OUT;
        end else begin
          phase_nxt = PH_RES;
          state_nxt = S_NDIV;
          start_nxt = 1'b1;
        end
      end
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
      aw_r    <= '0;
      an_r    <= '0;
      ad_r    <= val_t'(1);
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      aw_r    <= aw_nxt;
      an_r    <= an_nxt;
      ad_r    <= ad_nxt;
    end
    phase_r <= phase_nxt; op_r <= op_nxt; status_r <= status_nxt;
    ow_r <= ow_nxt; on_r <= on_nxt; od_r <= od_nxt; f_r <= f_nxt;
    rw_r <= rw_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
    x_r <= x_nxt; y_r <= y_nxt; g_r <= g_nxt; ta_r <= ta_nxt; t1_r <= t1_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.res_whole = aw_r;
  assign out_ch.res_num   = an_r;
  assign out_ch.res_den   = ad_r;
  assign out_ch.status    = status_r;

endmodule
`default_nettype wire

// File: rtl/core/mfa_checker.sv
// Port-level checker for the mixed fraction accumulator, bound to the top level.
`default_nettype none
module mfa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [62:0] res_num,
  input wire logic [62:0] res_den,
  input wire logic [1:0]  status
);
  import mfa_pkg::*;

  // A held result keeps its numerator, denominator and status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(res_den)
      && $stable(status)) else $error("result changed while stalled");

  a_proper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> res_den != '0 && res_num < res_den)
    else $error("fraction not proper");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second transaction while busy");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready && status != ST_RSVD)
    else $error("bad result status or overlap");

endmodule

bind mixed_fraction_accumulator_top mfa_checker u_mfa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .res_num  (out_ch.res_num),
  .res_den  (out_ch.res_den),
  .status   (out_ch.status)
);
`default_nettype wire
